// File: rtl/wsc_pkg.sv
// Shared types and constants for the wavetable sound channel.
// Holds request codes, register map, volume codes and the controller/datapath link.
// No dependencies.
package wsc_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_ADVANCE = 2'd2;
  localparam logic [1:0] ACT_LENGTH  = 2'd3;

  // Control register map
  localparam logic [4:0] REG_DAC     = 5'd0;
  localparam logic [4:0] REG_LENGTH  = 5'd1;
  localparam logic [4:0] REG_VOLUME  = 5'd2;
  localparam logic [4:0] REG_PER_LO  = 5'd3;
  localparam logic [4:0] REG_CONTROL = 5'd4;

  // Read-back masks: unused bits read as one
  localparam logic [7:0] MASK_DAC     = 8'h7F;
  localparam logic [7:0] MASK_VOLUME  = 8'h9F;
  localparam logic [7:0] MASK_CONTROL = 8'hBF;
  localparam logic [7:0] READ_OPEN    = 8'hFF;

  // Volume codes
  localparam logic [1:0] VOL_MUTE    = 2'd0;
  localparam logic [1:0] VOL_FULL    = 2'd1;
  localparam logic [1:0] VOL_HALF    = 2'd2;
  localparam logic [1:0] VOL_QUARTER = 2'd3;

  localparam logic [8:0] LENGTH_FULL = 9'd256;

  typedef struct packed {
    logic load;   // latch the accepted request
    logic exec;   // apply the request to the channel state
    logic wrap;   // one period reload, advance position
    logic fetch;  // capture a wave-memory read byte, read the playing wave byte
    logic emit;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic wrap_due;  // timer ran out during an advance
    logic out_free;  // result register can take a new result
  } sts_t;

  // Timer reload: (2048 - period) * 2
  function automatic logic [12:0] reload_of(input logic [10:0] period);
    logic [11:0] diff;
    diff = 12'd2048 - {1'b0, period};
    return {diff, 1'b0};
  endfunction

endpackage

// File: rtl/wsc_ctrl.sv
// Request sequencer for the wavetable sound channel.
// Drives wsc_datapath through wsc_pkg::cmd_t; depends on wsc_pkg.
module wsc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wsc_pkg::sts_t sts,
  output wsc_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_STEP   = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        // spin on the reload adder until the timer is positive again
        if (sts.wrap_due) begin
          cmd.wrap = 1'b1;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/wsc_datapath.sv
// Channel state, wave memory, period timer and result register.
// Commanded by wsc_ctrl; depends on wsc_pkg.
module wsc_datapath #(
  parameter int WAVE_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_tuser,
  input  logic [23:0]   in_tdata,
  input  wsc_pkg::cmd_t cmd,
  output wsc_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata
);

  localparam int AW = $clog2(WAVE_BYTES);

  // latched request
  logic [1:0] act_r;
  logic [4:0] addr_r;
  logic [7:0] wdata_r;
  logic [7:0] cyc_r;

  // channel state
  logic [7:0]         dac_reg_r;
  logic [7:0]         vol_reg_r;
  logic [7:0]         ctl_reg_r;
  logic [7:0]         per_lo_r;
  logic               en_r;
  logic [8:0]         len_r;
  logic [AW:0]        pos_r;
  logic signed [13:0] timer_r;

  // wave memory
  logic [7:0]            wave_mem [WAVE_BYTES];
  logic [WAVE_BYTES-1:0] vld_r;
  logic [7:0]            mem_q_r;
  logic                  mem_q_vld_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_ra;

  logic [7:0] rd_r;

  logic       out_vld_r;
  logic [7:0] out_rd_r;
  logic [3:0] out_smp_r;
  logic       out_on_r;

  logic [10:0]        period;
  logic signed [13:0] reload;
  logic               is_wave;
  logic [7:0]         bus_rd;
  logic [8:0]         len_dec;
  logic [7:0]         wave_byte;
  logic [3:0]         nib;
  logic [3:0]         sample;

  assign period  = {ctl_reg_r[2:0], per_lo_r};
  assign reload  = $signed({1'b0, wsc_pkg::reload_of(period)});
  assign is_wave = addr_r[4];
  assign len_dec = (len_r != 9'd0) ? len_r - 9'd1 : 9'd0;

  always_comb begin
    case (addr_r)
      wsc_pkg::REG_DAC:     bus_rd = dac_reg_r | wsc_pkg::MASK_DAC;
      wsc_pkg::REG_VOLUME:  bus_rd = vol_reg_r | wsc_pkg::MASK_VOLUME;
      wsc_pkg::REG_CONTROL: bus_rd = ctl_reg_r | wsc_pkg::MASK_CONTROL;
      default:              bus_rd = wsc_pkg::READ_OPEN;
    endcase
  end

  assign sts.wrap_due = (act_r == wsc_pkg::ACT_ADVANCE) && en_r && (timer_r <= 14'sd0);
  assign sts.out_free = !out_vld_r || out_tready;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r   <= in_tuser;
      addr_r  <= in_tdata[4:0];
      wdata_r <= in_tdata[12:5];
      cyc_r   <= in_tdata[20:13];
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dac_reg_r <= '0;
      vol_reg_r <= '0;
      ctl_reg_r <= '0;
      per_lo_r  <= '0;
      en_r      <= 1'b0;
      len_r     <= '0;
      pos_r     <= '0;
      timer_r   <= '0;
    end else if (cmd.exec) begin
      case (act_r)
        wsc_pkg::ACT_WRITE: begin
          case (addr_r)
            wsc_pkg::REG_DAC: begin
              dac_reg_r <= wdata_r;
              if (!wdata_r[7]) begin
                en_r <= 1'b0;
              end
            end
            wsc_pkg::REG_LENGTH: begin
              len_r <= wsc_pkg::LENGTH_FULL - {1'b0, wdata_r};
            end
            wsc_pkg::REG_VOLUME: begin
              vol_reg_r <= wdata_r;
            end
            wsc_pkg::REG_PER_LO: begin
              per_lo_r <= wdata_r;
            end
            wsc_pkg::REG_CONTROL: begin
              ctl_reg_r <= wdata_r;
              if (wdata_r[7]) begin
                // trigger: restart from the first sample with a fresh period
                en_r    <= dac_reg_r[7];
                pos_r   <= '0;
                timer_r <= $signed({1'b0, wsc_pkg::reload_of({wdata_r[2:0], per_lo_r})});
                if (len_r == 9'd0) begin
                  len_r <= wsc_pkg::LENGTH_FULL;
                end
              end
            end
            default: begin
            end
          endcase
        end
        wsc_pkg::ACT_ADVANCE: begin
          if (en_r) begin
            timer_r <= timer_r - $signed({6'd0, cyc_r});
          end
        end
        wsc_pkg::ACT_LENGTH: begin
          if (ctl_reg_r[6]) begin
            len_r <= len_dec;
            if (len_dec == 9'd0) begin
              en_r <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.wrap) begin
      timer_r <= timer_r + reload;
      pos_r   <= pos_r + 1'b1;
    end
  end

  // wave memory: one write and one registered read port
  assign mem_we = cmd.exec && (act_r == wsc_pkg::ACT_WRITE) && is_wave;
  assign mem_re = cmd.exec || cmd.fetch;
  assign mem_ra = cmd.fetch ? pos_r[AW:1] : addr_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[addr_r[AW-1:0]] <= wdata_r;
    end
    if (mem_re) begin
      mem_q_r <= wave_mem[mem_ra];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      mem_q_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[addr_r[AW-1:0]] <= 1'b1;
      end
      if (mem_re) begin
        mem_q_vld_r <= vld_r[mem_ra];
      end
    end
  end

  assign wave_byte = mem_q_vld_r ? mem_q_r : 8'd0;

  // read data: control registers at exec, wave byte once it is out of the memory
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r <= (act_r == wsc_pkg::ACT_READ) ? bus_rd : 8'd0;
    end else if (cmd.fetch && act_r == wsc_pkg::ACT_READ && is_wave) begin
      rd_r <= wave_byte;
    end
  end

  // even positions play the high nibble
  assign nib = pos_r[0] ? wave_byte[3:0] : wave_byte[7:4];

  always_comb begin
    if (!en_r || !dac_reg_r[7]) begin
      sample = 4'd0;
    end else begin
      case (vol_reg_r[6:5])
        wsc_pkg::VOL_FULL:    sample = nib;
        wsc_pkg::VOL_HALF:    sample = nib >> 1;
        wsc_pkg::VOL_QUARTER: sample = nib >> 2;
        default:              sample = 4'd0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_rd_r  <= rd_r;
      out_smp_r <= sample;
      out_on_r  <= en_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_on_r, out_smp_r, out_rd_r};

  a_en_needs_dac: assert property (@(posedge clk) disable iff (!rst_n)
    en_r |-> dac_reg_r[7])
    else $error("channel enabled with DAC off");

  a_wrap_only_when_due: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wrap |-> (timer_r <= 14'sd0) && en_r)
    else $error("reload step issued while timer still running");

  a_timer_live_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && en_r) |-> (timer_r > 14'sd0))
    else $error("result emitted with an expired period timer");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |-> !cmd.emit)
    else $error("result overwritten before it was taken");

endmodule

// File: rtl/wavetable_sound_channel.sv
// Top level of the wavetable sound channel.
// Instantiates wsc_ctrl and wsc_datapath; depends on wsc_pkg.
//
// Wave playback voice with five byte-wide control registers (0..4) and a
// wave memory of WAVE_BYTES bytes (32 four-bit samples) at addresses 16..31.
// Each input request is a register read, a register write, a timer advance
// by a cycle count, or a length clock, selected by in_tuser; every request
// returns exactly one result carrying the read data (0 for non-reads, 0xFF
// for unmapped reads), the current volume-scaled sample and the channel-on
// flag, all taken after the request has been applied. Writing register 4
// with bit 7 set triggers playback from position 0. A request passes from
// acceptance through the apply, step and result states, and a timer
// advance runs one reload step for every period reload that it crosses:
// the reload loop runs on a single adder, one reload per cycle.
// Requests are handled one at a time; a finished result waits in the
// output register while the next request is accepted, and the block
// stalls only when a second result is ready before the first is taken.
// Wave memory reads back zero until written; no clearing pass is needed
// after reset.
module wavetable_sound_channel #(
  parameter int WAVE_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [23:0] in_tdata,   // [4:0] reg_addr, [12:5] write_data, [20:13] cycles
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [11:8] sample, [12] channel_on
);

  wsc_pkg::cmd_t cmd;
  wsc_pkg::sts_t sts;

  // sequencer: accept, apply, run the reload loop, fetch the sample, emit
  wsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // registers, wave memory, period timer and the result register
  wsc_datapath #(
    .WAVE_BYTES (WAVE_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
